// ===== design/stepper_step_dir_pulse_generator_top_macros.svh =====
// Assertion macros used by the checker file of the pulse generator.
`ifndef STEPPER_STEP_DIR_PULSE_GENERATOR_TOP_MACROS_SVH
`define STEPPER_STEP_DIR_PULSE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and quiet during reset
`define SDPG_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pulse generator check failed");

// Next-cycle implication, sampled on clk_i and quiet during reset
`define SDPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pulse generator check failed");

`endif

// ===== design/stpgen_pkg.sv =====
`timescale 1ns / 1ps
package stpgen_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MIN_DELAY  = 2'd0;
  localparam logic [1:0] REG_MAX_DELAY  = 2'd1;
  localparam logic [1:0] REG_WAKE_DELAY = 2'd2;

  // Register reset values
  localparam logic [15:0] MIN_DELAY_RST  = 16'd1;
  localparam logic [15:0] MAX_DELAY_RST  = 16'd100;
  localparam logic [7:0]  WAKE_DELAY_RST = 8'd1;

  // Direction codes of a motion command
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;

  // Full speed in percent
  localparam logic [6:0] SPEED_FULL = 7'd100;

  // Divide by 100 as multiply by ceil(2^30 / 100), exact for products below 2^23
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [23:0] RECIP_100   = 24'd10737419;

  // Result bit positions inside the output tdata byte
  localparam int unsigned RES_STEP  = 0;
  localparam int unsigned RES_DIR   = 1;
  localparam int unsigned RES_SLEEP = 2;
  localparam int unsigned RES_RUN   = 3;
  localparam int unsigned RES_FAULT = 4;
  localparam int unsigned RES_DONE  = 5;

  // One result item
  typedef struct packed {
    logic count_done;
    logic fault_stop;
    logic running;
    logic sleep_n;
    logic dir_level;
    logic step_pulse;
  } result_t;

endpackage

// ===== design/stepper_step_dir_pulse_generator_top.sv =====
`timescale 1ns / 1ps
// Output: a result is held in the output register, valid from the cycle after its item is accepted.
// Throughput: ticks and stop commands one per cycle unless the result side stalls; a run
// command holds off further items while the interval multiplier pipeline
// (range times speed, then reciprocal of 100) produces the new step interval.
// Reset: asynchronous, active low; clears all control state and loads register defaults.
module stepper_step_dir_pulse_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // request side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // direction, speed, step_count, fault_n, pad
  input  logic        s_axis_tuser_i,  // func
  // result side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o   // step_pulse, dir_level, sleep_n, running,
                                       // fault_stop, count_done, pad
);

  // Configuration registers
  logic [15:0] min_q, max_q;
  logic [7:0]  wake_q;

  // Motion state
  logic        running_q, running_d;
  logic        skip_q, skip_d;
  logic        dir_q, dir_d;
  logic        awake_q, awake_d;
  logic        finite_q, finite_d;
  logic [15:0] wait_q, wait_d;
  logic [15:0] steps_q, steps_d;
  logic [15:0] interval_q;

  // Interval pipeline
  logic [1:0]  pend_q;
  logic [22:0] prod_q;
  logic [15:0] range;
  logic [6:0]  speed_c;
  logic [6:0]  speed_k;
  logic [46:0] recip_prod;
  logic [15:0] interval_new;

  // Output register
  logic                   out_valid_q;
  stpgen_pkg::result_t    out_q;
  stpgen_pkg::result_t    res;

  // Request fields
  logic        in_acc;
  logic        run_cmd;
  logic        func;
  logic [1:0]  direction;
  logic [6:0]  speed;
  logic [15:0] count;
  logic        fault_n;
  logic [15:0] steps_dec;

  assign func      = s_axis_tuser_i;
  assign direction = s_axis_tdata_i[1:0];
  assign speed     = s_axis_tdata_i[8:2];
  assign count     = s_axis_tdata_i[24:9];
  assign fault_n   = s_axis_tdata_i[25];

  // Accept when the output slot frees up and no interval is in flight
  assign s_axis_tready_o = (pend_q == 2'b00) && (!out_valid_q || m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign run_cmd         = in_acc && !func && (direction != stpgen_pkg::DIR_STOP) &&
                           (speed != 7'd0);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= stpgen_pkg::MIN_DELAY_RST;
      max_q  <= stpgen_pkg::MAX_DELAY_RST;
      wake_q <= stpgen_pkg::WAKE_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        stpgen_pkg::REG_MIN_DELAY:  min_q  <= cfg_wdata_i;
        stpgen_pkg::REG_MAX_DELAY:  max_q  <= cfg_wdata_i;
        stpgen_pkg::REG_WAKE_DELAY: wake_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Stage one of the interval: saturated range times speed complement
  always_comb begin
    range   = (max_q > min_q) ? (max_q - min_q) : 16'd0;
    speed_c = (speed > stpgen_pkg::SPEED_FULL) ? stpgen_pkg::SPEED_FULL : speed;
    speed_k = stpgen_pkg::SPEED_FULL - speed_c;
  end

  // Stage two: divide by 100 through the reciprocal, then add the minimum
  assign recip_prod   = 47'(prod_q) * 47'(stpgen_pkg::RECIP_100);
  assign interval_new = min_q + recip_prod[stpgen_pkg::RECIP_SHIFT +: 16];

  // Hold the product of a run command; the user must keep configuration put meanwhile (not enforced)
  always_ff @(posedge clk_i) begin
    if (run_cmd) begin
      prod_q <= 23'(range) * 23'(speed_k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 2'b00;
      interval_q <= 16'd0;
    end else begin
      pend_q <= {pend_q[0], run_cmd};
      if (pend_q[1]) begin
        interval_q <= interval_new;
      end
    end
  end

  // Next motion state and result of the accepted request
  always_comb begin
    running_d = running_q;
    skip_d    = skip_q;
    dir_d     = dir_q;
    awake_d   = awake_q;
    finite_d  = finite_q;
    wait_d    = wait_q;
    steps_d   = steps_q;
    steps_dec = (steps_q != 16'd0) ? (steps_q - 16'd1) : 16'd0;
    res       = '0;
    if (in_acc) begin
      if (!func) begin
        if ((direction == stpgen_pkg::DIR_STOP) || (speed == 7'd0)) begin
          running_d = 1'b0;
          awake_d   = 1'b0;
        end else begin
          if (!running_q) begin
            awake_d   = 1'b1;
            running_d = 1'b1;
            skip_d    = 1'b1;
            wait_d    = {8'd0, wake_q};
          end
          dir_d    = (direction == stpgen_pkg::DIR_CW);
          steps_d  = count;
          finite_d = (count != 16'd0);
        end
      end else if (running_q) begin
        if (wait_q > 16'd1) begin
          // count down toward the next step
          wait_d = wait_q - 16'd1;
        end else if (skip_q || fault_n) begin
          // step now and reload the wait
          skip_d         = 1'b0;
          res.step_pulse = 1'b1;
          wait_d         = interval_q;
          if (finite_q) begin
            steps_d = steps_dec;
            if (steps_dec == 16'd0) begin
              running_d      = 1'b0;
              awake_d        = 1'b0;
              res.count_done = 1'b1;
            end
          end
        end else begin
          // fault at step time: stop and sleep
          running_d      = 1'b0;
          awake_d        = 1'b0;
          res.fault_stop = 1'b1;
        end
      end
    end
    res.dir_level = dir_d;
    res.sleep_n   = awake_d;
    res.running   = running_d;
  end

  // Motion state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      skip_q    <= 1'b0;
      dir_q     <= 1'b0;
      awake_q   <= 1'b0;
      finite_q  <= 1'b0;
      wait_q    <= 16'd0;
      steps_q   <= 16'd0;
    end else begin
      running_q <= running_d;
      skip_q    <= skip_d;
      dir_q     <= dir_d;
      awake_q   <= awake_d;
      finite_q  <= finite_d;
      wait_q    <= wait_d;
      steps_q   <= steps_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_acc || (out_valid_q && !m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q};

endmodule

// ===== design/stpgen_checker.sv =====
`timescale 1ns / 1ps
`include "stepper_step_dir_pulse_generator_top_macros.svh"
module stpgen_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  // Hold a stalled result
  `SDPG_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // Keep the driver awake whenever stepping
  `SDPG_ASSERT(a_run_awake, m_axis_tvalid_o && m_axis_tdata_o[stpgen_pkg::RES_RUN], m_axis_tdata_o[stpgen_pkg::RES_SLEEP])

  // A pulse either keeps running or completes the count
  `SDPG_ASSERT(a_pulse_run, m_axis_tvalid_o && m_axis_tdata_o[stpgen_pkg::RES_STEP], m_axis_tdata_o[stpgen_pkg::RES_RUN] || m_axis_tdata_o[stpgen_pkg::RES_DONE])

  // A fault stop drops the pulse and leaves the driver asleep
  `SDPG_ASSERT(a_fault_halt, m_axis_tvalid_o && m_axis_tdata_o[stpgen_pkg::RES_FAULT], !m_axis_tdata_o[stpgen_pkg::RES_STEP] && !m_axis_tdata_o[stpgen_pkg::RES_RUN] && !m_axis_tdata_o[stpgen_pkg::RES_SLEEP])

endmodule

bind stepper_step_dir_pulse_generator_top stpgen_checker u_stpgen_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/stepper_step_dir_pulse_generator_top_tb.sv =====
`timescale 1ns / 1ps
module stepper_step_dir_pulse_generator_top_tb;

  // Item kinds and the direction codes the package leaves out
  localparam bit         FUNC_CMD  = 1'b0;
  localparam bit         FUNC_TICK = 1'b1;
  localparam logic [1:0] DIR_CCW   = 2'd2;
  localparam logic [1:0] DIR_ALT   = 2'd3;  // decoded as counter-clockwise

  localparam int unsigned PERCENT      = 100;
  localparam int          CHUNK_ITEMS  = 70;
  localparam int          DRAIN_CYCLES = 6;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          IDLE_LIMIT   = 4000;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_addr_i      = '0;
  logic [15:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;

  stepper_step_dir_pulse_generator_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),  // direction, speed, step_count, fault_n, pad
    .s_axis_tuser_i  (s_axis_tuser_i),  // func
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)   // step_pulse, dir_level, sleep_n, running,
                                        // fault_stop, count_done, pad
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Motion state mirror and register copies
  int unsigned dly_min  = 32'(stpgen_pkg::MIN_DELAY_RST);
  int unsigned dly_max  = 32'(stpgen_pkg::MAX_DELAY_RST);
  int unsigned dly_wake = 32'(stpgen_pkg::WAKE_DELAY_RST);
  bit          mot_running;
  bit          mot_first_step;
  bit          mot_dir_cw;
  bit          mot_awake;
  int unsigned mot_wait;
  int unsigned mot_steps_left;
  bit          mot_finite;
  int unsigned mot_interval;

  stpgen_pkg::result_t pin_q[$];
  int      err_cnt;
  int      src_idle_pct;
  int      sink_stall_pct;
  int      hold_reqs;
  int      hold_seen;
  int      hold_left;
  int      quiet_cycles;

  // Step interval for a speed from the current register copies
  function automatic int unsigned interval_for_speed(logic [6:0] spd);
    int unsigned pct;
    int unsigned span;
    pct  = (spd > stpgen_pkg::SPEED_FULL) ? PERCENT : 32'(spd);
    span = (dly_max > dly_min) ? dly_max - dly_min : 0;
    return (dly_min + (span * (PERCENT - pct)) / PERCENT) & 32'hFFFF;
  endfunction

  // Advance the motion mirror by one request and return the pin levels it yields
  function automatic stpgen_pkg::result_t predict_pins(bit func, logic [1:0] dir,
                                                       logic [6:0] spd,
                                                       logic [15:0] cnt, bit fault_n);
    stpgen_pkg::result_t r;
    r = '0;
    if (func == FUNC_CMD) begin
      if (dir == stpgen_pkg::DIR_STOP || spd == 7'd0) begin
        mot_running = 1'b0;
        mot_awake   = 1'b0;
      end else begin
        if (!mot_running) begin
          mot_awake      = 1'b1;
          mot_running    = 1'b1;
          mot_first_step = 1'b1;
          mot_wait       = dly_wake;
        end
        mot_dir_cw     = (dir == stpgen_pkg::DIR_CW);
        mot_interval   = interval_for_speed(spd);
        mot_steps_left = 32'(cnt);
        mot_finite     = (cnt != 16'd0);
      end
    end else if (mot_running) begin
      if (mot_wait > 1) begin
        mot_wait--;
      end else if (mot_first_step || fault_n) begin
        mot_first_step = 1'b0;
        r.step_pulse   = 1'b1;
        mot_wait       = mot_interval;
        if (mot_finite) begin
          if (mot_steps_left > 0) mot_steps_left--;
          if (mot_steps_left == 0) begin
            mot_running  = 1'b0;
            mot_awake    = 1'b0;
            r.count_done = 1'b1;
          end
        end
      end else begin
        mot_running  = 1'b0;
        mot_awake    = 1'b0;
        r.fault_stop = 1'b1;
      end
    end
    r.dir_level = mot_dir_cw;
    r.sleep_n   = mot_awake;
    r.running   = mot_running;
    return r;
  endfunction

  // Offer one request, wait for the handshake, then record the expected pins
  task automatic send_item(bit func, logic [1:0] dir, logic [6:0] spd,
                           logic [15:0] cnt, bit fault_n);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= func;
    s_axis_tdata_i  <= {6'd0, fault_n, cnt, spd, dir};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pin_q.push_back(predict_pins(func, dir, spd, cnt, fault_n));
  endtask

  task automatic send_cmd(logic [1:0] dir, logic [6:0] spd, logic [15:0] cnt);
    send_item(FUNC_CMD, dir, spd, cnt, 1'($urandom_range(1)));
  endtask

  // Command fields ride along on a tick with random content
  task automatic send_tick(bit fault_n);
    send_item(FUNC_TICK, 2'($urandom_range(3)), 7'($urandom_range(127)),
              16'($urandom), fault_n);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_tick(1'b1);
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pin_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_delays(logic [15:0] min_v, logic [15:0] max_v, logic [7:0] wake_v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= stpgen_pkg::REG_MIN_DELAY;
    cfg_wdata_i <= min_v;
    @(posedge clk_i);
    cfg_addr_i  <= stpgen_pkg::REG_MAX_DELAY;
    cfg_wdata_i <= max_v;
    @(posedge clk_i);
    cfg_addr_i  <= stpgen_pkg::REG_WAKE_DELAY;
    cfg_wdata_i <= {8'd0, wake_v};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    dly_min  = 32'(min_v);
    dly_max  = 32'(max_v);
    dly_wake = 32'(wake_v);
  endtask

  function automatic logic [15:0] pick_delay(int small_hi);
    int r;
    r = $urandom_range(99);
    if (r < 75) return 16'($urandom_range(small_hi));
    if (r < 85) return 16'($urandom_range(300));
    if (r < 93) return 16'($urandom);
    return (r < 96) ? 16'd0 : 16'hFFFF;
  endfunction

  task automatic write_random_delays();
    logic [7:0] wake_v;
    wake_v = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(4));
    write_delays(pick_delay(4), pick_delay(12), wake_v);
  endtask

  // Run command with a mostly short step count
  task automatic send_random_run();
    logic [1:0]  dir;
    logic [6:0]  spd;
    logic [15:0] cnt;
    int          r;
    r   = $urandom_range(2);
    dir = (r == 0) ? stpgen_pkg::DIR_CW : ((r == 1) ? DIR_CCW : DIR_ALT);
    spd = ($urandom_range(4) == 0) ? 7'($urandom_range(1, 127)) : 7'($urandom_range(1, 100));
    r   = $urandom_range(99);
    cnt = (r < 35) ? 16'd0 : ((r < 90) ? 16'($urandom_range(1, 8)) : 16'($urandom));
    send_cmd(dir, spd, cnt);
  endtask

  // Known corner behavior under the reset register values
  task automatic test_directed();
    send_tick(1'b0);                     // tick while stopped does nothing
    send_cmd(stpgen_pkg::DIR_CW, stpgen_pkg::SPEED_FULL, 16'd2);
    send_tick(1'b0);                     // fault ignored on first step after wake
    send_tick(1'b1);                     // count used up
    send_cmd(DIR_CCW, 7'd50, 16'd0);
    send_cmd(DIR_ALT, 7'd127, 16'd0);    // retarget while running, speed clamps
    send_tick(1'b1);
    send_tick(1'b0);                     // fault stop
    send_cmd(stpgen_pkg::DIR_CW, 7'd0, 16'd5);       // speed zero sleeps
    send_cmd(stpgen_pkg::DIR_CW, 7'd1, 16'hFFFF);
    send_tick(1'b1);
    send_tick(1'b1);
    send_cmd(stpgen_pkg::DIR_STOP, stpgen_pkg::SPEED_FULL, 16'd3);
    send_tick(1'b1);
    send_cmd(stpgen_pkg::DIR_CW, stpgen_pkg::SPEED_FULL, 16'd1);
    send_tick(1'b0);                     // single step ends count despite fault
    send_item(FUNC_CMD, DIR_ALT, 7'h7F, 16'hFFFF, 1'b1);
    send_item(FUNC_TICK, DIR_ALT, 7'h7F, 16'hFFFF, 1'b1);
    send_item(FUNC_TICK, stpgen_pkg::DIR_STOP, 7'd0, 16'd0, 1'b1);
    send_cmd(stpgen_pkg::DIR_STOP, 7'd0, 16'd0);
    drain();
  endtask

  // Register extremes: inverted range, longest wake, zero and full-scale delays
  task automatic test_delay_extremes();
    write_delays(16'hFFFF, 16'h0000, 8'hFF);
    send_cmd(stpgen_pkg::DIR_CW, 7'd50, 16'd2);
    send_ticks(257);
    send_cmd(stpgen_pkg::DIR_STOP, 7'd10, 16'd0);
    drain();
    write_delays(16'h0000, 16'hFFFF, 8'h00);
    send_cmd(DIR_CCW, 7'd1, 16'd0);
    send_ticks(2);
    send_cmd(stpgen_pkg::DIR_CW, stpgen_pkg::SPEED_FULL, 16'd3);
    send_ticks(2);
    send_cmd(stpgen_pkg::DIR_STOP, 7'd0, 16'd0);
    send_cmd(stpgen_pkg::DIR_CW, stpgen_pkg::SPEED_FULL, 16'd3);
    send_ticks(4);
    drain();
    write_delays(16'hFFFF, 16'hFFFF, 8'h00);
    send_cmd(stpgen_pkg::DIR_CW, stpgen_pkg::SPEED_FULL, 16'd0);
    send_ticks(2);
    send_cmd(stpgen_pkg::DIR_STOP, stpgen_pkg::SPEED_FULL, 16'd0);
    drain();
  endtask

  // Mostly run commands followed by tick trains, plus stops and noise
  task automatic test_random_traffic(int n_items, int src_pct, int sink_pct);
    int r;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % CHUNK_ITEMS == 0) begin
        drain();
        write_random_delays();
      end
      r = $urandom_range(99);
      if (r < 6) begin
        send_item(1'($urandom_range(1)), 2'($urandom_range(3)), 7'($urandom_range(127)),
                  16'($urandom), 1'($urandom_range(1)));
      end else if (r < 10 || (!mot_running && r < 55)) begin
        send_random_run();
      end else if (r < 13) begin
        if ($urandom_range(1)) begin
          send_cmd(stpgen_pkg::DIR_STOP, 7'($urandom_range(127)), 16'($urandom));
        end else begin
          send_cmd(2'($urandom_range(1, 3)), 7'd0, 16'($urandom));
        end
      end else begin
        send_tick(1'($urandom_range(19) != 0));
      end
    end
    drain();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  // Hold the receiver off while the sender keeps offering requests
  task automatic test_backpressure();
    write_delays(16'd1, 16'd3, 8'd1);
    hold_reqs <= hold_reqs + 1;
    send_cmd(stpgen_pkg::DIR_CW, 7'd80, 16'd0);
    repeat (30) send_tick(1'b1);
    send_cmd(DIR_CCW, stpgen_pkg::SPEED_FULL, 16'd4);
    repeat (8) send_tick(1'b1);
    drain();
  endtask

  // Receiver ready with random stalls and an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen       <= hold_reqs;
      hold_left       <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each result with the oldest expected pin set
  always @(posedge clk_i) begin
    stpgen_pkg::result_t got;
    stpgen_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = stpgen_pkg::result_t'(m_axis_tdata_o[5:0]);
      if (pin_q.size() == 0) begin
        $display("%0t unexpected result %b", $time, got);
        err_cnt++;
      end else begin
        want = pin_q.pop_front();
        if (got.step_pulse !== want.step_pulse) begin
          $display("%0t step_pulse exp %b got %b", $time, want.step_pulse, got.step_pulse);
          err_cnt++;
        end
        if (got.dir_level !== want.dir_level) begin
          $display("%0t dir_level exp %b got %b", $time, want.dir_level, got.dir_level);
          err_cnt++;
        end
        if (got.sleep_n !== want.sleep_n) begin
          $display("%0t sleep_n exp %b got %b", $time, want.sleep_n, got.sleep_n);
          err_cnt++;
        end
        if (got.running !== want.running) begin
          $display("%0t running exp %b got %b", $time, want.running, got.running);
          err_cnt++;
        end
        if (got.fault_stop !== want.fault_stop) begin
          $display("%0t fault_stop exp %b got %b", $time, want.fault_stop, got.fault_stop);
          err_cnt++;
        end
        if (got.count_done !== want.count_done) begin
          $display("%0t count_done exp %b got %b", $time, want.count_done, got.count_done);
          err_cnt++;
        end
      end
    end
  end

  // Abort when neither side has moved a request for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_delay_extremes();
    test_random_traffic(350, 0, 0);
    test_random_traffic(350, 72, 0);
    test_random_traffic(350, 0, 72);
    test_random_traffic(350, 15, 15);
    test_backpressure();
    drain();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
